FILE: rtl/d2q9_pkg.sv
package d2q9_pkg;

    // Number format and lattice size
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 28;
    localparam int RATE_W   = FRAC_W + 2;
    localparam int NDIR     = 9;
    localparam int SUM_W    = DATA_W + 4;
    localparam int IB_W     = DATA_W - 1 - FRAC_W;

    // Pipeline depths
    localparam int DIV_LAT  = DATA_W + 1;
    localparam int LANE_LAT = 7;

    // Internal widths of the equilibrium datapath
    localparam int SQ_W   = 2 * DATA_W - FRAC_W;
    localparam int UKE_W  = SQ_W + 1;
    localparam int WR_W   = SUM_W - 1;
    localparam int CU_W   = DATA_W + 1;
    localparam int CU2_W  = 2 * CU_W - FRAC_W;
    localparam int P_W    = CU2_W + 6;
    localparam int PL_W   = P_W / 2;
    localparam int FEQ_W  = WR_W + P_W - FRAC_W;
    localparam int FL_W   = FEQ_W / 2;
    localparam int OF_W   = RATE_W + FEQ_W - FRAC_W;
    localparam int OG_W   = RATE_W + DATA_W - FRAC_W;
    localparam int G_W    = OF_W + 2;

    localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(387912588);
    localparam logic [RATE_W-1:0] ONE_Q    = RATE_W'(longint'(1) << FRAC_W);

    localparam logic [FRAC_W-1:0] W_REST =
        FRAC_W'(((longint'(8) << FRAC_W) + 9) / 18);
    localparam logic [FRAC_W-1:0] W_AXIS =
        FRAC_W'(((longint'(2) << FRAC_W) + 9) / 18);
    localparam logic [FRAC_W-1:0] W_DIAG =
        FRAC_W'(((longint'(2) << FRAC_W) + 36) / 72);

    // Direction components
    localparam logic signed [1:0] DIR_POS  = 2'sd1;
    localparam logic signed [1:0] DIR_NEG  = -2'sd1;
    localparam logic signed [1:0] DIR_ZERO = 2'sd0;

    typedef logic signed [DATA_W-1:0] t_val;
    typedef logic [NDIR-1:0][DATA_W-1:0] t_vec;

    typedef struct packed {
        t_val f_rest;
        t_val f_east;
        t_val f_north;
        t_val f_west;
        t_val f_south;
        t_val f_northeast;
        t_val f_northwest;
        t_val f_southwest;
        t_val f_southeast;
    } t_in;

    typedef struct packed {
        t_val g_rest;
        t_val g_east;
        t_val g_north;
        t_val g_west;
        t_val g_south;
        t_val g_northeast;
        t_val g_northwest;
        t_val g_southwest;
        t_val g_southeast;
        logic bad_density;
    } t_out;

    typedef struct packed {
        logic signed [1:0]  cx;
        logic signed [1:0]  cy;
        logic [FRAC_W-1:0]  w;
    } t_dir;

    // Relaxation factor with its complement (1 - omega) in sign/magnitude
    typedef struct packed {
        logic [RATE_W-1:0] om;
        logic [RATE_W-1:0] om1_mag;
        logic              om1_neg;
    } t_relax;

    localparam t_dir DIR_TAB [NDIR] = '{
        '{DIR_ZERO, DIR_ZERO, W_REST},
        '{DIR_POS,  DIR_ZERO, W_AXIS},
        '{DIR_ZERO, DIR_POS,  W_AXIS},
        '{DIR_NEG,  DIR_ZERO, W_AXIS},
        '{DIR_ZERO, DIR_NEG,  W_AXIS},
        '{DIR_POS,  DIR_POS,  W_DIAG},
        '{DIR_NEG,  DIR_POS,  W_DIAG},
        '{DIR_NEG,  DIR_NEG,  W_DIAG},
        '{DIR_POS,  DIR_NEG,  W_DIAG}
    };

    function automatic t_vec in_to_vec(t_in x);
        t_vec v;
        v[0] = x.f_rest;
        v[1] = x.f_east;
        v[2] = x.f_north;
        v[3] = x.f_west;
        v[4] = x.f_south;
        v[5] = x.f_northeast;
        v[6] = x.f_northwest;
        v[7] = x.f_southwest;
        v[8] = x.f_southeast;
        return v;
    endfunction

    function automatic t_out vec_to_out(t_vec g, logic bad);
        t_out r;
        r.g_rest      = g[0];
        r.g_east      = g[1];
        r.g_north     = g[2];
        r.g_west      = g[3];
        r.g_south     = g[4];
        r.g_northeast = g[5];
        r.g_northwest = g[6];
        r.g_southwest = g[7];
        r.g_southeast = g[8];
        r.bad_density = bad;
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sx_sum(logic [DATA_W-1:0] x);
        return {{(SUM_W - DATA_W){x[DATA_W-1]}}, x};
    endfunction

    function automatic t_relax relax_of(logic [RATE_W-1:0] om);
        t_relax          r;
        logic [RATE_W:0] d;
        logic [RATE_W:0] dn;
        d         = {1'b0, ONE_Q} - {1'b0, om};
        dn        = -d;
        r.om      = om;
        r.om1_neg = d[RATE_W];
        r.om1_mag = d[RATE_W] ? dn[RATE_W-1:0] : d[RATE_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/d2q9_moments.sv
module d2q9_moments (
    input  logic                             i_clk,
    input  logic                             i_adv,
    input  d2q9_pkg::t_in                    i_item,
    output d2q9_pkg::t_in                    o_item,
    output logic signed [d2q9_pkg::SUM_W-1:0] o_rho,
    output logic signed [d2q9_pkg::SUM_W-1:0] o_mx,
    output logic signed [d2q9_pkg::SUM_W-1:0] o_my
);
    import d2q9_pkg::*;

    t_vec                    v;
    logic signed [SUM_W-1:0] n_rho;
    logic signed [SUM_W-1:0] n_mx;
    logic signed [SUM_W-1:0] n_my;
    t_in                     r_item;
    logic signed [SUM_W-1:0] r_rho;
    logic signed [SUM_W-1:0] r_mx;
    logic signed [SUM_W-1:0] r_my;

    assign v = in_to_vec(i_item);

    // Sum density and both momentum components
    always_comb begin
        n_rho = '0;
        n_mx  = '0;
        n_my  = '0;
        for (int i = 0; i < NDIR; i++) begin
            n_rho = n_rho + sx_sum(v[i]);
            if (DIR_TAB[i].cx == DIR_POS) n_mx = n_mx + sx_sum(v[i]);
            if (DIR_TAB[i].cx == DIR_NEG) n_mx = n_mx - sx_sum(v[i]);
            if (DIR_TAB[i].cy == DIR_POS) n_my = n_my + sx_sum(v[i]);
            if (DIR_TAB[i].cy == DIR_NEG) n_my = n_my - sx_sum(v[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= i_item;
            r_rho  <= n_rho;
            r_mx   <= n_mx;
            r_my   <= n_my;
        end
    end

    assign o_item = r_item;
    assign o_rho  = r_rho;
    assign o_mx   = r_mx;
    assign o_my   = r_my;

endmodule

FILE: rtl/d2q9_div.sv
module d2q9_div (
    input  logic                              i_clk,
    input  logic                              i_adv,
    input  logic signed [d2q9_pkg::SUM_W-1:0]  i_num,
    input  logic signed [d2q9_pkg::SUM_W-1:0]  i_den,
    output logic signed [d2q9_pkg::DATA_W-1:0] o_quo
);
    import d2q9_pkg::*;

    localparam int NSTEP = DATA_W - 1;
    localparam logic [DATA_W-1:0] MAXV = {1'b0, {(DATA_W - 1){1'b1}}};

    logic [SUM_W-1:0]  num_neg;
    logic [SUM_W-1:0]  un;
    logic [SUM_W-1:0]  ud;
    logic [SUM_W-1:0]  un_hi;

    logic [SUM_W-1:0]  r_rem [NSTEP];
    logic [DATA_W-2:0] r_nlo [NSTEP];
    logic [SUM_W-1:0]  r_den [NSTEP];
    logic [DATA_W-2:0] r_q   [NSTEP+1];
    logic              r_neg [NSTEP+1];
    logic              r_ovf [NSTEP+1];

    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] n_quo;
    logic [DATA_W-1:0] r_quo;

    // Magnitude of the numerator; the integer part decides saturation
    assign num_neg = -i_num;
    assign un      = i_num[SUM_W-1] ? num_neg : i_num;
    assign ud      = i_den;
    assign un_hi   = un >> IB_W;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= un_hi;
            r_nlo[0] <= {un[IB_W-1:0], {FRAC_W{1'b0}}};
            r_den[0] <= ud;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[SUM_W-1];
            r_ovf[0] <= (un_hi >= ud);
        end
    end

    // One restoring step per stage
    for (genvar k = 1; k <= NSTEP; k++) begin : g_step
        logic [SUM_W:0] rs;
        logic [SUM_W:0] diff;
        logic           ge;

        assign rs   = {r_rem[k-1], r_nlo[k-1][DATA_W-2]};
        assign diff = rs - {1'b0, r_den[k-1]};
        assign ge   = (rs >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_q[k]   <= {r_q[k-1][DATA_W-3:0], ge};
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < NSTEP) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k] <= ge ? diff[SUM_W-1:0] : rs[SUM_W-1:0];
                    r_nlo[k] <= r_nlo[k-1] << 1;
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    // Saturate symmetrically and restore the sign
    assign mag   = r_ovf[NSTEP] ? MAXV : {1'b0, r_q[NSTEP]};
    assign n_quo = r_neg[NSTEP] ? -mag : mag;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

FILE: rtl/d2q9_lane.sv
module d2q9_lane (
    input  logic                              i_clk,
    input  logic                              i_adv,
    input  d2q9_pkg::t_dir                    i_dir,
    input  d2q9_pkg::t_relax                  i_relax,
    input  logic signed [d2q9_pkg::DATA_W-1:0] i_ux,
    input  logic signed [d2q9_pkg::DATA_W-1:0] i_uy,
    input  logic [d2q9_pkg::UKE_W-1:0]         i_uke,
    input  logic signed [d2q9_pkg::SUM_W-1:0]  i_rho,
    input  logic [d2q9_pkg::DATA_W-1:0]        i_f,
    output logic [d2q9_pkg::DATA_W-1:0]        o_g,
    output logic [d2q9_pkg::DATA_W-1:0]        o_f
);
    import d2q9_pkg::*;

    localparam logic signed [G_W-1:0] G_MAX =
        G_W'((longint'(1) << (DATA_W - 1)) - 1);
    localparam logic signed [G_W-1:0] G_MIN = -G_MAX - G_W'(1);

    // Stage 1: projected velocity and weighted density
    logic signed [CU_W-1:0]       uxe, uye, tx, ty;
    logic [FRAC_W+WR_W-1:0]       wr_full;
    logic signed [CU_W-1:0]       r1_cu;
    logic [WR_W-1:0]              r1_wr;
    logic [UKE_W-1:0]             r1_uke;
    logic [DATA_W-1:0]            r1_f;

    assign uxe = {i_ux[DATA_W-1], i_ux};
    assign uye = {i_uy[DATA_W-1], i_uy};

    always_comb begin
        tx = '0;
        ty = '0;
        if (i_dir.cx == DIR_POS) tx = uxe;
        if (i_dir.cx == DIR_NEG) tx = -uxe;
        if (i_dir.cy == DIR_POS) ty = uye;
        if (i_dir.cy == DIR_NEG) ty = -uye;
    end

    assign wr_full = i_dir.w * i_rho[SUM_W-2:0];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_cu  <= tx + ty;
            r1_wr  <= wr_full[FRAC_W+WR_W-1:FRAC_W];
            r1_uke <= i_uke;
            r1_f   <= i_f;
        end
    end

    // Stage 2: square of the projection, linear and kinetic terms
    logic [CU_W-1:0]              cu_mag;
    logic [2*CU_W-1:0]            cu_sq;
    logic signed [P_W-1:0]        cu_ext;
    logic [UKE_W+1:0]             k3;
    logic [CU2_W-1:0]             r2_cu2;
    logic signed [P_W-1:0]        r2_t3;
    logic [UKE_W:0]               r2_kh;
    logic [WR_W-1:0]              r2_wr;
    logic [DATA_W-1:0]            r2_f;

    assign cu_mag = r1_cu[CU_W-1] ? -r1_cu : r1_cu;
    assign cu_sq  = cu_mag * cu_mag;
    assign cu_ext = {{(P_W - CU_W){r1_cu[CU_W-1]}}, r1_cu};
    assign k3     = {2'b00, r1_uke} + {1'b0, r1_uke, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_cu2 <= cu_sq[2*CU_W-1:FRAC_W];
            r2_t3  <= cu_ext + (cu_ext <<< 1);
            r2_kh  <= k3[UKE_W+1:1];
            r2_wr  <= r1_wr;
            r2_f   <= r1_f;
        end
    end

    // Stage 3: polynomial in sign/magnitude form
    logic [CU2_W+3:0]             n9;
    logic signed [P_W-1:0]        poly;
    logic [P_W-1:0]               poly_neg;
    logic [P_W-1:0]               r3_pmag;
    logic                         r3_pneg;
    logic [WR_W-1:0]              r3_wr;
    logic [DATA_W-1:0]            r3_f;

    assign n9       = {4'b0000, r2_cu2} + {1'b0, r2_cu2, 3'b000};
    assign poly     = P_W'(ONE_Q) + r2_t3
                    + P_W'(n9[CU2_W+3:1]) - P_W'(r2_kh);
    assign poly_neg = -poly;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_pmag <= poly[P_W-1] ? poly_neg : poly;
            r3_pneg <= poly[P_W-1];
            r3_wr   <= r2_wr;
            r3_f    <= r2_f;
        end
    end

    // Stage 4: partial products of the equilibrium value
    logic [WR_W+PL_W-1:0]         r4_lo;
    logic [WR_W+P_W-PL_W-1:0]     r4_hi;
    logic                         r4_pneg;
    logic [DATA_W-1:0]            r4_f;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_lo   <= r3_wr * r3_pmag[PL_W-1:0];
            r4_hi   <= r3_wr * r3_pmag[P_W-1:PL_W];
            r4_pneg <= r3_pneg;
            r4_f    <= r3_f;
        end
    end

    // Stage 5: combine partials and truncate
    logic [WR_W+P_W-1:0]          feq_full;
    logic [FEQ_W-1:0]             r5_feq;
    logic                         r5_neg;
    logic [DATA_W-1:0]            r5_f;

    assign feq_full = {r4_hi, {PL_W{1'b0}}} + (WR_W + P_W)'(r4_lo);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_feq <= feq_full[WR_W+P_W-1:FRAC_W];
            r5_neg <= r4_pneg;
            r5_f   <= r4_f;
        end
    end

    // Stage 6: relaxation products
    logic [DATA_W-1:0]            f_mag;
    logic [RATE_W+DATA_W-1:0]     og_full;
    logic [RATE_W+FL_W-1:0]       r6_plo;
    logic [RATE_W+FEQ_W-FL_W-1:0] r6_phi;
    logic                         r6_neg;
    logic [OG_W-1:0]              r6_og;
    logic                         r6_ogneg;
    logic [DATA_W-1:0]            r6_f;

    assign f_mag   = r5_f[DATA_W-1] ? -r5_f : r5_f;
    assign og_full = i_relax.om1_mag * f_mag;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_plo   <= i_relax.om * r5_feq[FL_W-1:0];
            r6_phi   <= i_relax.om * r5_feq[FEQ_W-1:FL_W];
            r6_neg   <= r5_neg;
            r6_og    <= og_full[RATE_W+DATA_W-1:FRAC_W];
            r6_ogneg <= i_relax.om1_neg ^ r5_f[DATA_W-1];
            r6_f     <= r5_f;
        end
    end

    // Stage 7: add both terms and saturate
    logic [RATE_W+FEQ_W-1:0]      of_full;
    logic signed [G_W-1:0]        of_s;
    logic signed [G_W-1:0]        og_s;
    logic signed [G_W-1:0]        g_sum;
    logic signed [G_W-1:0]        g_sat;
    logic [DATA_W-1:0]            r7_g;
    logic [DATA_W-1:0]            r7_f;

    assign of_full = {r6_phi, {FL_W{1'b0}}} + (RATE_W + FEQ_W)'(r6_plo);

    always_comb begin
        of_s = G_W'(of_full[RATE_W+FEQ_W-1:FRAC_W]);
        og_s = G_W'(r6_og);
        if (r6_neg)   of_s = -of_s;
        if (r6_ogneg) og_s = -og_s;
        g_sum = of_s + og_s;
        g_sat = g_sum;
        if (g_sum > G_MAX) g_sat = G_MAX;
        if (g_sum < G_MIN) g_sat = G_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r7_g <= g_sat[DATA_W-1:0];
            r7_f <= r6_f;
        end
    end

    assign o_g = r7_g;
    assign o_f = r7_f;

endmodule

FILE: rtl/d2q9_bgk_collision.sv
// Channel  | Direction | Handshake            | Payload
// item in  | input     | i_valid / o_stall    | i_item   (nine distributions)
// result   | output    | o_valid / i_stall    | o_result (nine values, bad_density)
// relax    | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (omega, Q2.28)
//
// One site is accepted per cycle while o_stall is low. Its velocity is formed by
// the two restoring dividers, one per component, each with 31 restoring steps.
// Reset is synchronous: pipeline and output valids clear, omega returns to its
// reset value. A stalled output fills one skid entry, then o_stall rises and the
// whole pipeline holds until the result is taken. o_cfg_ready is always high.
module d2q9_bgk_collision (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  d2q9_pkg::t_in                 i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output d2q9_pkg::t_out                o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [d2q9_pkg::RATE_W-1:0]   i_cfg_data
);
    import d2q9_pkg::*;

    localparam int DLY   = DIV_LAT + 2;
    localparam int PLEN  = 1 + DLY + LANE_LAT;

    typedef struct packed {
        t_in                     item;
        logic signed [SUM_W-1:0] rho;
        logic                    bad;
    } t_dly;

    logic                    adv;
    logic [PLEN-1:0]         r_vld;
    t_relax                  r_relax;
    logic                    r_out_vld;
    logic                    r_skid_vld;

    // Relaxation register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax <= relax_of(RATE_RST);
        end else if (i_cfg_valid) begin
            r_relax <= relax_of(i_cfg_data);
        end
    end

    // Advance the pipeline whenever the skid entry is free
    assign adv     = !r_skid_vld;
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PLEN-2:0], i_valid};
        end
    end

    // Moments
    t_in                     mo_item;
    logic signed [SUM_W-1:0] mo_rho;
    logic signed [SUM_W-1:0] mo_mx;
    logic signed [SUM_W-1:0] mo_my;

    d2q9_moments u_moments (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_item (i_item),
        .o_item (mo_item),
        .o_rho  (mo_rho),
        .o_mx   (mo_mx),
        .o_my   (mo_my)
    );

    // Velocity dividers
    logic signed [DATA_W-1:0] ux;
    logic signed [DATA_W-1:0] uy;

    d2q9_div u_div_x (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num (mo_mx),
        .i_den (mo_rho),
        .o_quo (ux)
    );

    d2q9_div u_div_y (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num (mo_my),
        .i_den (mo_rho),
        .o_quo (uy)
    );

    // Carry the site and its density alongside the dividers
    t_dly r_dl [DLY];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dl[0] <= '{item: mo_item, rho: mo_rho, bad: !(mo_rho > 0)};
            for (int k = 1; k < DLY; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // Squared speed
    logic signed [2*DATA_W-1:0] px;
    logic signed [2*DATA_W-1:0] py;
    logic [SQ_W-1:0]            r_sqx;
    logic [SQ_W-1:0]            r_sqy;
    logic signed [DATA_W-1:0]   r_ux1, r_uy1, r_ux2, r_uy2;
    logic [UKE_W-1:0]           r_uke;

    assign px = ux * ux;
    assign py = uy * uy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqx <= px[2*DATA_W-1:FRAC_W];
            r_sqy <= py[2*DATA_W-1:FRAC_W];
            r_ux1 <= ux;
            r_uy1 <= uy;
            r_uke <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_ux2 <= r_ux1;
            r_uy2 <= r_uy1;
        end
    end

    // Lanes, one per direction
    t_vec dl_vec;
    t_vec lane_g;
    t_vec lane_f;

    assign dl_vec = in_to_vec(r_dl[DLY-1].item);

    for (genvar i = 0; i < NDIR; i++) begin : g_lane
        d2q9_lane u_lane (
            .i_clk   (i_clk),
            .i_adv   (adv),
            .i_dir   (DIR_TAB[i]),
            .i_relax (r_relax),
            .i_ux    (r_ux2),
            .i_uy    (r_uy2),
            .i_uke   (r_uke),
            .i_rho   (r_dl[DLY-1].rho),
            .i_f     (dl_vec[i]),
            .o_g     (lane_g[i]),
            .o_f     (lane_f[i])
        );
    end

    // Delay the density flag across the lanes
    logic r_bad [LANE_LAT];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bad[0] <= r_dl[DLY-1].bad;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_bad[k] <= r_bad[k-1];
            end
        end
    end

    // Merge: pass inputs through when density is not positive
    t_out merged;

    assign merged = vec_to_out(r_bad[LANE_LAT-1] ? lane_f : lane_g, r_bad[LANE_LAT-1]);

    // Output register with one skid entry
    t_out r_out;
    t_out r_skid;
    logic take;
    logic arrive;

    assign take   = r_out_vld && !i_stall;
    assign arrive = adv && r_vld[PLEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (arrive) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (arrive) begin
            if (!r_out_vld || take) begin
                r_out <= merged;
            end else begin
                r_skid <= merged;
            end
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without an output item");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_stall))
        else $error("skid entry filled while output was free");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> $stable(r_vld))
        else $error("pipeline advanced while skid entry was full");

endmodule

FILE: sim/tb_top.sv
module tb_top;
    import d2q9_pkg::*;

    localparam longint SAT_LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint Q_ONE    = longint'(1) << FRAC_W;
    localparam longint WT_REST  = ((longint'(8) << FRAC_W) + 9) / 18;
    localparam longint WT_AXIS  = ((longint'(2) << FRAC_W) + 9) / 18;
    localparam longint WT_DIAG  = ((longint'(2) << FRAC_W) + 36) / 72;
    localparam int     SETTLE   = 60;
    localparam int     WD_LIMIT = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    t_in                 in_site;
    logic                out_valid;
    logic                out_stall;
    t_out                out_site;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [RATE_W-1:0]   cfg_data;

    t_in                 site_q[$];
    t_out                expect_q[$];
    logic [RATE_W-1:0]   omega_cur;
    int                  err_cnt;
    int                  idle_cycles;
    int                  gap_left;
    int                  burst_left;
    int                  stall_pct;
    int                  stall_left;

    d2q9_bgk_collision uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_item      (in_site),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_result    (out_site),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Saturating arithmetic of the collision datapath
    function automatic longint sat_add(longint a, longint b);
        if (b > 0 && a > SAT_LIM - b) return SAT_LIM;
        if (b < 0 && a < -SAT_LIM - b) return -SAT_LIM;
        return a + b;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        logic [127:0] shr;
        longint       r;
        ma   = (a < 0) ? 64'(-a) : 64'(a);
        mb   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ma} * {64'd0, mb};
        shr  = prod >> FRAC_W;
        if (shr > 128'(SAT_LIM)) r = SAT_LIM;
        else r = longint'(shr[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // Velocity: quotient truncated, saturated to the data range
    function automatic longint q_div(longint n, longint d);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] vmax;
        vmax = (64'd1 << (DATA_W - 1)) - 1;
        un   = (n < 0) ? 64'(-n) : 64'(n);
        ud   = 64'(d);
        q    = un / ud;
        r    = un % ud;
        if (q >= (64'd1 << IB_W)) begin
            q = vmax;
        end else begin
            for (int k = 0; k < FRAC_W; k++) begin
                r = r << 1;
                q = q << 1;
                if (r >= ud) begin
                    r = r - ud;
                    q = q | 64'd1;
                end
            end
            if (q > vmax) q = vmax;
        end
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint site_dist(t_in s, int i);
        logic [NDIR*DATA_W-1:0] flat;
        flat = s;
        return longint'(signed'(flat[DATA_W*(NDIR-1-i) +: DATA_W]));
    endfunction

    function automatic t_out collide(t_in s, logic [RATE_W-1:0] om);
        int     cx[NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
        int     cy[NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
        longint wt[NDIR];
        longint f[NDIR];
        longint rho, mx, my, ux, uy, uke, omega, cu, p, feq, g, gmax;
        logic [NDIR*DATA_W:0] flat;
        wt   = '{WT_REST, WT_AXIS, WT_AXIS, WT_AXIS, WT_AXIS,
                 WT_DIAG, WT_DIAG, WT_DIAG, WT_DIAG};
        gmax = (longint'(1) << (DATA_W - 1)) - 1;
        rho  = 0;
        mx   = 0;
        my   = 0;
        for (int i = 0; i < NDIR; i++) begin
            f[i] = site_dist(s, i);
            rho  = sat_add(rho, f[i]);
            mx   = sat_add(mx, cx[i] * f[i]);
            my   = sat_add(my, cy[i] * f[i]);
        end
        // Non-positive density: pass the site through and flag it
        if (rho <= 0) return t_out'({s, 1'b1});
        ux    = q_div(mx, rho);
        uy    = q_div(my, rho);
        uke   = sat_add(q_mul(ux, ux), q_mul(uy, uy));
        omega = longint'(om);
        flat  = '0;
        for (int i = 0; i < NDIR; i++) begin
            cu  = sat_add(cx[i] * ux, cy[i] * uy);
            p   = sat_add(Q_ONE, q_mul(cu, longint'(3) << FRAC_W));
            p   = sat_add(p, q_mul(q_mul(cu, cu), longint'(9) << (FRAC_W - 1)));
            p   = sat_add(p, -q_mul(uke, longint'(3) << (FRAC_W - 1)));
            feq = q_mul(q_mul(wt[i], rho), p);
            g   = sat_add(q_mul(omega, feq), q_mul(Q_ONE - omega, f[i]));
            if (g > gmax) g = gmax;
            if (g < -gmax - 1) g = -gmax - 1;
            flat[1 + DATA_W*(NDIR-1-i) +: DATA_W] = g[DATA_W-1:0];
        end
        return t_out'(flat);
    endfunction

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Sender: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        logic took;
        logic nv;
        t_in  ns;
        int   ng;
        int   nb;
        took = in_valid && !in_stall;
        nv   = in_valid;
        ns   = in_site;
        ng   = gap_left;
        nb   = burst_left;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (took) expect_q.push_back(collide(in_site, omega_cur));
            if (!in_valid || took) begin
                nv = 1'b0;
                if (ng > 0) begin
                    ng--;
                end else if (site_q.size() > 0) begin
                    nv = 1'b1;
                    ns = site_q.pop_front();
                    if (nb > 0) begin
                        nb--;
                    end else begin
                        nb = $urandom_range(0, 40);
                        ng = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        in_valid   <= nv;
        in_site    <= ns;
        gap_left   <= ng;
        burst_left <= nb;
    end

    // Receiver: stall pattern that changes density over time
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(20, 300);
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end else begin
            stall_left <= stall_left - 1;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        logic [NDIR*DATA_W:0] got_b;
        logic [NDIR*DATA_W:0] want_b;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expect_q.size() == 0) begin
                report("result with no site outstanding");
            end else begin
                want   = expect_q.pop_front();
                got_b  = out_site;
                want_b = want;
                for (int i = 0; i < NDIR; i++)
                    if (got_b[1 + DATA_W*(NDIR-1-i) +: DATA_W]
                            !== want_b[1 + DATA_W*(NDIR-1-i) +: DATA_W])
                        report($sformatf("direction %0d got %h want %h", i,
                            got_b[1 + DATA_W*(NDIR-1-i) +: DATA_W],
                            want_b[1 + DATA_W*(NDIR-1-i) +: DATA_W]));
                if (out_site.bad_density !== want.bad_density)
                    report($sformatf("bad_density got %b want %b",
                        out_site.bad_density, want.bad_density));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_in pack_site(longint v[NDIR]);
        logic [NDIR*DATA_W-1:0] flat;
        for (int i = 0; i < NDIR; i++)
            flat[DATA_W*(NDIR-1-i) +: DATA_W] = v[i][DATA_W-1:0];
        return t_in'(flat);
    endfunction

    // Near-equilibrium site with random density and velocity
    function automatic t_in flow_site();
        longint v[NDIR];
        longint wt[NDIR];
        longint rho;
        int     spread;
        wt     = '{WT_REST, WT_AXIS, WT_AXIS, WT_AXIS, WT_AXIS,
                   WT_DIAG, WT_DIAG, WT_DIAG, WT_DIAG};
        rho    = longint'($urandom_range(1, 1 << 30));
        spread = $urandom_range(0, 3) == 0 ? 26 : 20;
        for (int i = 0; i < NDIR; i++)
            v[i] = q_mul(wt[i], rho)
                   + longint'(signed'(32'($urandom))) / (longint'(1) << (31 - spread));
        return pack_site(v);
    endfunction

    function automatic t_in noise_site();
        longint v[NDIR];
        for (int i = 0; i < NDIR; i++)
            v[i] = longint'(signed'(32'($urandom)));
        return pack_site(v);
    endfunction

    function automatic t_in random_site();
        int     pick;
        longint v[NDIR];
        pick = $urandom_range(0, 99);
        if (pick < 70) return flow_site();
        if (pick < 85) return noise_site();
        // Negative density or strong one-sided momentum
        for (int i = 0; i < NDIR; i++)
            v[i] = (pick < 93) ? -longint'($urandom_range(0, 1 << 29))
                               : longint'($urandom_range(0, 1 << 20));
        if (pick >= 93)
            v[$urandom_range(1, 8)] = longint'($urandom_range(1 << 28, 32'h7FFF_FFFF));
        return pack_site(v);
    endfunction

    // Check between edges so that every transfer of the last edge has settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (site_q.size() != 0 || expect_q.size() != 0 || in_valid);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_omega(logic [RATE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk);
        while (!cfg_ready);
        omega_cur <= v;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed_sites();
        longint v[NDIR];
        longint mx_v;
        longint mn_v;
        mx_v = longint'(32'sh7FFF_FFFF);
        mn_v = -longint'(32'sh7FFF_FFFF) - 1;
        v = '{default: 0};
        site_q.push_back(pack_site(v));
        v = '{default: mx_v};
        site_q.push_back(pack_site(v));
        v = '{default: mn_v};
        site_q.push_back(pack_site(v));
        v = '{default: 0};
        v[0] = 1;
        site_q.push_back(pack_site(v));
        v[0] = Q_ONE;
        site_q.push_back(pack_site(v));
        // Single direction carries all mass: velocity of one lattice unit
        for (int d = 1; d < NDIR; d++) begin
            v = '{default: 0};
            v[d] = Q_ONE;
            site_q.push_back(pack_site(v));
        end
        // Tiny density, huge momentum: velocity saturates
        v = '{default: 0};
        v[1] = mx_v;
        v[3] = -mx_v + 1;
        site_q.push_back(pack_site(v));
        v = '{default: 0};
        v[2] = mn_v;
        v[4] = mx_v;
        v[0] = mx_v;
        site_q.push_back(pack_site(v));
        v = '{default: mx_v};
        v[0] = mn_v;
        site_q.push_back(pack_site(v));
        v = '{mx_v, mn_v, mx_v, mn_v, mx_v, mn_v, mx_v, mn_v, mx_v};
        site_q.push_back(pack_site(v));
        v = '{default: -1};
        site_q.push_back(pack_site(v));
        for (int k = 0; k < 4; k++) site_q.push_back(flow_site());
    endtask

    initial begin
        logic [RATE_W-1:0] rates[6];
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_site    = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        omega_cur  = RATE_RST;
        err_cnt    = 0;
        gap_left   = 0;
        burst_left = 0;
        stall_pct  = 0;
        stall_left = 0;
        rates = '{RATE_RST, '0, RATE_W'(1) << 29, '1, ONE_Q,
                  RATE_W'($urandom_range(1, 1 << 29))};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_omega(rates[ph]);
            directed_sites();
            for (int k = 0; k < 260; k++) site_q.push_back(random_site());
            wait_idle();
        end
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: sim.f
rtl/d2q9_pkg.sv
rtl/d2q9_moments.sv
rtl/d2q9_div.sv
rtl/d2q9_lane.sv
rtl/d2q9_bgk_collision.sv
sim/tb_top.sv
